@@ rtl/ctmp_pkg.sv @@
// ----------------------------------------------------------------------------
// ctmp_pkg
// shared types, codes and helpers of the short-form difference string parser
// ----------------------------------------------------------------------------
`default_nettype none

package ctmp_pkg;

  // queue depths
  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW    = $clog2(FQ_DEPTH);
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);

  // operator codes
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_IDENT = 3'd1;
  localparam logic [2:0] OP_SUBST = 3'd2;
  localparam logic [2:0] OP_INS   = 3'd3;
  localparam logic [2:0] OP_DEL   = 3'd4;
  localparam logic [2:0] OP_UNSUP = 3'd5;

  // record kinds
  localparam logic [1:0] KIND_SUBST = 2'd0;
  localparam logic [1:0] KIND_INS   = 2'd1;
  localparam logic [1:0] KIND_DEL   = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  // end status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNSUP     = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;

  // substitution base count
  localparam logic [1:0] SEG_NONE = 2'd0;
  localparam logic [1:0] SEG_ONE  = 2'd1;
  localparam logic [1:0] SEG_TWO  = 2'd2;

  // characters
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  localparam logic [35:0] RUN_BASE = 36'd10;

  // input request
  typedef struct packed {
    logic [7:0] character;
    logic       end_of_string;
  } in_t;

  // result record
  typedef struct packed {
    logic [1:0]  record_kind;
    logic [31:0] ref_position;
    logic [7:0]  read_letter;
    logic [7:0]  ref_letter;
    logic [1:0]  parse_status;
    logic        last_record;
  } out_t;

  // classified character
  typedef struct packed {
    logic [2:0] oc;
    logic       is_digit;
    logic [3:0] digit;
    logic [7:0] letter;
    logic       eos;
  } class_t;

  // front to back feed
  typedef struct packed {
    logic   valid;
    class_t item;
  } feed_t;

  // back to result queue write
  typedef struct packed {
    logic [1:0] num;
    out_t       first;
    out_t       second;
  } wr_t;

  function automatic logic [2:0] op_code(input logic [7:0] c);
    logic [2:0] r;
    case (c)
      CH_COLON: r = OP_IDENT;
      CH_STAR:  r = OP_SUBST;
      CH_PLUS:  r = OP_INS;
      CH_MINUS: r = OP_DEL;
      CH_EQUAL: r = OP_UNSUP;
      CH_TILDE: r = OP_UNSUP;
      default:  r = OP_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
      r = c - CASE_GAP;
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/ctmp_front.sv @@
// ----------------------------------------------------------------------------
// ctmp_front
// classifies each character and holds it in a short queue for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module ctmp_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  output logic                full,
  input  wire ctmp_pkg::in_t  item,
  output ctmp_pkg::feed_t     feed,
  input  wire logic           take
);

  ctmp_pkg::class_t          entries [ctmp_pkg::FQ_DEPTH];
  logic [ctmp_pkg::FQ_AW-1:0] wp;
  logic [ctmp_pkg::FQ_AW-1:0] rp;
  logic [ctmp_pkg::FQ_AW:0]   count;
  ctmp_pkg::class_t          cls;
  logic                      wr_en;
  logic                      rd_en;
  logic [7:0]                diff;

  // classify the incoming character
  always_comb begin
    diff         = item.character - ctmp_pkg::CH_ZERO;
    cls.oc       = ctmp_pkg::op_code(item.character);
    cls.is_digit = (item.character >= ctmp_pkg::CH_ZERO) &&
                   (item.character <= ctmp_pkg::CH_NINE);
    cls.digit    = diff[3:0];
    cls.letter   = ctmp_pkg::upcase(item.character);
    cls.eos      = item.end_of_string;
  end

  assign full  = (count == (ctmp_pkg::FQ_AW+1)'(ctmp_pkg::FQ_DEPTH));
  assign wr_en = push && !full;
  assign rd_en = take && feed.valid;

  assign feed.valid = (count != '0);
  assign feed.item  = entries[rp];

  // queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wp] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wp <= wp + 1'b1;
      end
      if (rd_en) begin
        rp <= rp + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (ctmp_pkg::FQ_AW+1)'(ctmp_pkg::FQ_DEPTH))
    else $error("front queue over depth");
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    rd_en && !wr_en |=> count == $past(count) - 1'b1)
    else $error("front queue count slip on read");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    wr_en && !rd_en |=> count == $past(count) + 1'b1)
    else $error("front queue count slip on write");

endmodule

`default_nettype wire

@@ rtl/ctmp_back.sv @@
// ----------------------------------------------------------------------------
// ctmp_back
// segment state machine: tracks operator, runs and position, builds records
// ----------------------------------------------------------------------------
`default_nettype none

module ctmp_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ctmp_pkg::feed_t  feed,
  output logic                  take,
  input  wire logic             room,
  output ctmp_pkg::wr_t         wr
);

  logic [2:0]  op;
  logic [1:0]  seg;
  logic [7:0]  held;
  logic [31:0] acc;
  logic [31:0] off;
  logic [1:0]  err;

  logic [2:0]  op_next;
  logic [1:0]  seg_next;
  logic [7:0]  held_next;
  logic [31:0] acc_next;
  logic [31:0] off_next;
  logic [1:0]  err_next;

  logic [31:0]      adv;
  logic [31:0]      off_m;
  logic [35:0]      run;
  logic             emit;
  ctmp_pkg::out_t   mut;
  ctmp_pkg::out_t   fin;
  ctmp_pkg::class_t it;

  assign it   = feed.item;
  assign take = feed.valid && room;

  // decimal run step: acc * 10 + digit
  assign run = {4'b0, acc} * ctmp_pkg::RUN_BASE + 36'(it.digit);

  // per character update
  always_comb begin
    op_next   = op;
    seg_next  = seg;
    held_next = held;
    acc_next  = acc;
    err_next  = err;
    adv       = '0;
    emit      = 1'b0;
    mut       = '0;
    if (err == ctmp_pkg::ST_OK) begin
      if (it.oc != ctmp_pkg::OP_NONE) begin
        // operator closes the open segment
        if (op == ctmp_pkg::OP_SUBST && seg == ctmp_pkg::SEG_ONE) begin
          err_next = ctmp_pkg::ST_MALFORMED;
        end
        if (op == ctmp_pkg::OP_IDENT) begin
          adv = acc;
        end
        op_next   = it.oc;
        seg_next  = ctmp_pkg::SEG_NONE;
        held_next = '0;
        acc_next  = '0;
      end else begin
        case (op)
          ctmp_pkg::OP_IDENT: begin
            if (!it.is_digit || run[35:32] != 4'd0) begin
              err_next = ctmp_pkg::ST_MALFORMED;
            end else begin
              acc_next = run[31:0];
              // run closed by end of string
              if (it.eos) begin
                adv = run[31:0];
              end
            end
          end
          ctmp_pkg::OP_SUBST: begin
            if (seg == ctmp_pkg::SEG_NONE) begin
              held_next = it.letter;
              seg_next  = ctmp_pkg::SEG_ONE;
            end else if (seg == ctmp_pkg::SEG_ONE) begin
              emit             = 1'b1;
              mut.record_kind  = ctmp_pkg::KIND_SUBST;
              mut.ref_position = off;
              mut.read_letter  = it.letter;
              mut.ref_letter   = held;
              adv              = 32'd1;
              seg_next         = ctmp_pkg::SEG_TWO;
            end else begin
              err_next = ctmp_pkg::ST_MALFORMED;
            end
          end
          ctmp_pkg::OP_INS: begin
            emit             = 1'b1;
            mut.record_kind  = ctmp_pkg::KIND_INS;
            mut.ref_position = off;
            mut.read_letter  = it.letter;
          end
          ctmp_pkg::OP_DEL: begin
            emit             = 1'b1;
            mut.record_kind  = ctmp_pkg::KIND_DEL;
            mut.ref_position = off;
            mut.ref_letter   = it.letter;
            adv              = 32'd1;
          end
          ctmp_pkg::OP_UNSUP: begin
            err_next = ctmp_pkg::ST_UNSUP;
          end
          default: begin
            err_next = ctmp_pkg::ST_MALFORMED;
          end
        endcase
      end
    end
    off_m = off + adv;

    // end of string: lone substitution base is malformed
    if (it.eos && err_next == ctmp_pkg::ST_OK &&
        op_next == ctmp_pkg::OP_SUBST && seg_next == ctmp_pkg::SEG_ONE) begin
      err_next = ctmp_pkg::ST_MALFORMED;
    end

    fin              = '0;
    fin.record_kind  = ctmp_pkg::KIND_END;
    fin.ref_position = off_m;
    fin.parse_status = err_next;
    fin.last_record  = 1'b1;
    off_next         = off_m;

    // records to the result queue
    wr = '0;
    if (take) begin
      if (emit && it.eos) begin
        wr.num    = 2'd2;
        wr.first  = mut;
        wr.second = fin;
      end else if (emit) begin
        wr.num   = 2'd1;
        wr.first = mut;
      end else if (it.eos) begin
        wr.num   = 2'd1;
        wr.first = fin;
      end
    end
  end

  // state registers, cleared after each string
  always_ff @(posedge clk) begin
    if (rst) begin
      op   <= ctmp_pkg::OP_NONE;
      seg  <= ctmp_pkg::SEG_NONE;
      held <= '0;
      acc  <= '0;
      off  <= '0;
      err  <= ctmp_pkg::ST_OK;
    end else if (take) begin
      if (it.eos) begin
        op   <= ctmp_pkg::OP_NONE;
        seg  <= ctmp_pkg::SEG_NONE;
        held <= '0;
        acc  <= '0;
        off  <= '0;
        err  <= ctmp_pkg::ST_OK;
      end else begin
        op   <= op_next;
        seg  <= seg_next;
        held <= held_next;
        acc  <= acc_next;
        off  <= off_next;
        err  <= err_next;
      end
    end
  end

  // checks
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    take && it.eos |=> op == ctmp_pkg::OP_NONE && off == '0 && err == ctmp_pkg::ST_OK)
    else $error("state not cleared after end of string");
  a_err_holds: assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(err) && $stable(off))
    else $error("state moved with no request taken");
  a_pair_is_end: assert property (@(posedge clk) disable iff (rst)
    wr.num == 2'd2 |-> wr.second.last_record && !wr.first.last_record)
    else $error("record pair without end record second");
  a_write_needs_take: assert property (@(posedge clk) disable iff (rst)
    wr.num != 2'd0 |-> take)
    else $error("record written without a request");

endmodule

`default_nettype wire

@@ rtl/ctmp_result_queue.sv @@
// ----------------------------------------------------------------------------
// ctmp_result_queue
// result queue taking up to two records a cycle, one out a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ctmp_result_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ctmp_pkg::wr_t  wr,
  output logic                room,
  output logic                empty,
  input  wire logic           pop,
  output ctmp_pkg::out_t      result
);

  ctmp_pkg::out_t             entries [ctmp_pkg::RQ_DEPTH];
  logic [ctmp_pkg::RQ_AW-1:0] wp;
  logic [ctmp_pkg::RQ_AW-1:0] wp_one;
  logic [ctmp_pkg::RQ_AW-1:0] rp;
  logic [ctmp_pkg::RQ_AW:0]   count;
  logic [ctmp_pkg::RQ_AW:0]   count_next;
  logic                       rd_en;

  assign empty  = (count == '0);
  assign rd_en  = pop && !empty;
  assign result = entries[rp];
  assign wp_one = wp + 1'b1;

  // space for a full pair from the back end
  assign room = (count <= (ctmp_pkg::RQ_AW+1)'(ctmp_pkg::RQ_DEPTH - 2));

  assign count_next = count + (ctmp_pkg::RQ_AW+1)'(wr.num) -
                      (ctmp_pkg::RQ_AW+1)'(rd_en);

  // storage
  always_ff @(posedge clk) begin
    if (wr.num != 2'd0) begin
      entries[wp] <= wr.first;
    end
    if (wr.num == 2'd2) begin
      entries[wp_one] <= wr.second;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + ctmp_pkg::RQ_AW'(wr.num);
      if (rd_en) begin
        rp <= rp + 1'b1;
      end
      count <= count_next;
    end
  end

  // checks
  a_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (ctmp_pkg::RQ_AW+1)'(ctmp_pkg::RQ_DEPTH))
    else $error("result queue over depth");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    wr.num != 2'd0 |-> room)
    else $error("result written without room");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    count != (ctmp_pkg::RQ_AW+1)'(ctmp_pkg::RQ_DEPTH) |->
      (ctmp_pkg::RQ_AW)'(wp - rp) == count[ctmp_pkg::RQ_AW-1:0])
    else $error("result queue pointers disagree with count");

endmodule

`default_nettype wire

@@ rtl/cs_tag_mutation_parser_unit.sv @@
// A character is registered in the front queue and, once the back end takes it, its records in the result queue.
// Throughput: one character per cycle while the result queue has room, set by the segment update in the back end.
// A final character that also closes a mutation gives two records, drained at one per cycle.
// Reset (rst, synchronous, active high) empties both queues and clears the parser state.
// ----------------------------------------------------------------------------
// cs_tag_mutation_parser_unit
// short-form difference string parser: classify front, segment back, result queue
// ----------------------------------------------------------------------------
`default_nettype none

module cs_tag_mutation_parser_unit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  output logic                full,
  input  wire ctmp_pkg::in_t  item,
  output logic                empty,
  input  wire logic           pop,
  output ctmp_pkg::out_t      result
);

  ctmp_pkg::feed_t feed;
  ctmp_pkg::wr_t   wr;
  logic            take;
  logic            room;

  // character classification and request queue
  ctmp_front u_front (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .item (item),
    .feed (feed),
    .take (take)
  );

  // segment state machine
  ctmp_back u_back (
    .clk  (clk),
    .rst  (rst),
    .feed (feed),
    .take (take),
    .room (room),
    .wr   (wr)
  );

  // result records
  ctmp_result_queue u_result_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .room   (room),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

`default_nettype wire
